// File: sv/maof_pkg.sv
// Shared types and constants for the mix accumulator output formatter.
`default_nettype none
package maof_pkg;

  typedef enum logic [1:0] {
    FMT_MULAW = 2'd0,
    FMT_LIN8  = 2'd1,
    FMT_LIN16 = 2'd2
  } fmt_t;

  typedef enum logic {
    REG_FORMAT   = 1'b0,
    REG_UNSIGNED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    fmt_t fmt;
    logic unsigned_output;
  } cfg_t;

  localparam int SAMPLE_W  = 32;
  localparam int FRAC_BITS = 12;
  localparam int CODE_W    = 16;
  localparam int BYTE_W    = 8;

  localparam int LIN16_SH = FRAC_BITS;
  localparam int LIN8_SH  = FRAC_BITS + 8;
  localparam int MULAW_SH = FRAC_BITS + 4;

  localparam logic signed [15:0] LIN16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] LIN16_MIN = -16'sh8000;
  localparam logic signed [7:0]  LIN8_MAX  = 8'sd127;
  localparam logic signed [7:0]  LIN8_MIN  = -8'sd127;
  localparam logic signed [12:0] MULAW_MAX = 13'sd4095;
  localparam logic signed [12:0] MULAW_MIN = -13'sd4096;

  localparam logic [14:0] MULAW_CLIP = 15'd8159;
  localparam logic [13:0] MULAW_BIAS = 14'd33;
  localparam logic [13:0] MULAW_SEG0 = 14'h3F;
  localparam int          MULAW_SEGS = 7;
  localparam logic [7:0]  MULAW_MASK_POS = 8'hFF;
  localparam logic [7:0]  MULAW_MASK_NEG = 8'h7F;

endpackage
`default_nettype wire

// File: sv/mix_accumulator_output_formatter_core.sv
// Top level: config registers, input register, format select, result register.
`default_nettype none
// Converts one 32-bit mixer accumulator sample (12 fraction bits) per beat into
// a 16-bit output code: 8-bit mu-law, 8-bit linear or 16-bit linear, with an
// optional midscale offset for linear formats; last_in rides along as last_out.
// One sample is accepted every cycle while accum_stall is low; a result passes
// through the input register and then the result register, with one pass of
// shift, clamp and encode logic between them. Write configuration only while
// no beat is in flight.
module mix_accumulator_output_formatter_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [1:0]                           cfg_data,
  input  wire logic                                 accum_valid,
  output logic                                      accum_stall,
  input  wire logic signed [maof_pkg::SAMPLE_W-1:0] accum_sample,
  input  wire logic                                 last_in,
  output logic                                      code_valid,
  input  wire logic                                 code_stall,
  output logic [maof_pkg::CODE_W-1:0]               out_code,
  output logic                                      last_out
);

  maof_pkg::cfg_t                    cfg;
  logic                              stage_valid;
  logic signed [maof_pkg::SAMPLE_W-1:0] stage_sample;
  logic                              stage_last;
  logic                              out_adv;
  logic                              stage_adv;
  logic [maof_pkg::CODE_W-1:0]       lin_code;
  logic [maof_pkg::BYTE_W-1:0]       mu_code;
  logic [maof_pkg::CODE_W-1:0]       code_next;

  assign cfg_ready   = 1'b1;
  assign out_adv     = !code_valid || !code_stall;
  assign stage_adv   = !stage_valid || out_adv;
  assign accum_stall = !stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt             <= maof_pkg::FMT_LIN16;
      cfg.unsigned_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (maof_pkg::reg_idx_t'(cfg_index))
        maof_pkg::REG_FORMAT:   cfg.fmt <= maof_pkg::fmt_t'(cfg_data);
        maof_pkg::REG_UNSIGNED: cfg.unsigned_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_adv) begin
      stage_valid <= accum_valid;
    end
    if (stage_adv && accum_valid) begin
      stage_sample <= accum_sample;
      stage_last   <= last_in;
    end
  end

  maof_linear u_linear (
    .sample (stage_sample),
    .cfg    (cfg),
    .code   (lin_code)
  );

  maof_mulaw u_mulaw (
    .sample (stage_sample),
    .code   (mu_code)
  );

  always_comb begin
    case (cfg.fmt)
      maof_pkg::FMT_MULAW: code_next = {8'h00, mu_code};
      default:             code_next = lin_code;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (out_adv) begin
      code_valid <= stage_valid;
    end
    if (out_adv && stage_valid) begin
      out_code <= code_next;
      last_out <= stage_last;
    end
  end

endmodule
`default_nettype wire

// File: sv/maof_linear.sv
// Linear 8-bit and 16-bit shift, clamp and midscale offset.
`default_nettype none
module maof_linear (
  input  wire logic signed [maof_pkg::SAMPLE_W-1:0] sample,
  input  wire maof_pkg::cfg_t                        cfg,
  output logic [maof_pkg::CODE_W-1:0]                code
);

  localparam int W16 = maof_pkg::SAMPLE_W - maof_pkg::LIN16_SH;
  localparam int W8  = maof_pkg::SAMPLE_W - maof_pkg::LIN8_SH;

  logic signed [W16-1:0] s16;
  logic signed [W8-1:0]  s8;
  logic [15:0]           c16;
  logic [7:0]            c8;

  assign s16 = sample[maof_pkg::SAMPLE_W-1:maof_pkg::LIN16_SH];
  assign s8  = sample[maof_pkg::SAMPLE_W-1:maof_pkg::LIN8_SH];

  always_comb begin
    if (s16 > W16'(maof_pkg::LIN16_MAX)) begin
      c16 = maof_pkg::LIN16_MAX;
    end else if (s16 < W16'(maof_pkg::LIN16_MIN)) begin
      c16 = maof_pkg::LIN16_MIN;
    end else begin
      c16 = s16[15:0];
    end
    if (s8 > W8'(maof_pkg::LIN8_MAX)) begin
      c8 = maof_pkg::LIN8_MAX;
    end else if (s8 < W8'(maof_pkg::LIN8_MIN)) begin
      c8 = maof_pkg::LIN8_MIN;
    end else begin
      c8 = s8[7:0];
    end
    // flip sign bit for midscale offset
    c16[15] = c16[15] ^ cfg.unsigned_output;
    c8[7]   = c8[7] ^ cfg.unsigned_output;
    if (cfg.fmt == maof_pkg::FMT_LIN8) begin
      code = {8'h00, c8};
    end else begin
      code = c16;
    end
  end

endmodule
`default_nettype wire

// File: sv/maof_mulaw.sv
// Mu-law shift, clamp and segment encoder.
`default_nettype none
module maof_mulaw (
  input  wire logic signed [maof_pkg::SAMPLE_W-1:0] sample,
  output logic [maof_pkg::BYTE_W-1:0]                code
);

  localparam int WS = maof_pkg::SAMPLE_W - maof_pkg::MULAW_SH;

  logic signed [WS-1:0] s;
  logic signed [12:0]   v;
  logic [13:0]          lin;
  logic                 neg;
  logic [14:0]          mag;
  logic [13:0]          biased;
  logic [2:0]           seg;
  logic [13:0]          shifted;

  assign s = sample[maof_pkg::SAMPLE_W-1:maof_pkg::MULAW_SH];

  always_comb begin
    if (s > WS'(maof_pkg::MULAW_MAX)) begin
      v = maof_pkg::MULAW_MAX;
    end else if (s < WS'(maof_pkg::MULAW_MIN)) begin
      v = maof_pkg::MULAW_MIN;
    end else begin
      v = s[12:0];
    end
    lin = {v, 1'b0};
    neg = v[12];
    mag = neg ? (15'd0 - {lin[13], lin}) : {1'b0, lin};
    if (mag > maof_pkg::MULAW_CLIP) begin
      mag = maof_pkg::MULAW_CLIP;
    end
    biased = mag[13:0] + maof_pkg::MULAW_BIAS;
    seg = 3'd0;
    for (int k = 0; k < maof_pkg::MULAW_SEGS; k++) begin
      if (biased > (maof_pkg::MULAW_SEG0 << k)) begin
        seg = seg + 3'd1;
      end
    end
    shifted = biased >> (4'(seg) + 4'd1);
    code = {1'b0, seg, shifted[3:0]} ^
           (neg ? maof_pkg::MULAW_MASK_NEG : maof_pkg::MULAW_MASK_POS);
  end

endmodule
`default_nettype wire

// File: sv/maof_checker.sv
// Port-level checker for the output formatter core and its bind.
`default_nettype none
module maof_port_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          accum_valid,
  input wire logic                          accum_stall,
  input wire logic                          last_in,
  input wire logic                          code_valid,
  input wire logic                          code_stall,
  input wire logic [maof_pkg::CODE_W-1:0]   out_code,
  input wire logic                          last_out
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !code_valid)
    else $error("result beat present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    accum_stall |-> (code_valid && code_stall))
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (code_valid && code_stall) |=> (code_valid && $stable(out_code) && $stable(last_out)))
    else $error("stalled result beat changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (accum_valid && !accum_stall && !code_stall) ##1 !code_stall
    |=> (code_valid && last_out == $past(last_in, 2)))
    else $error("result beat missing or last flag wrong");

endmodule

bind mix_accumulator_output_formatter_core maof_port_checker u_maof_checker (.*);
`default_nettype wire

// File: test/maof_checker.sv
// Checker for the output formatter: tracks config writes, predicts codes, compares results.
`timescale 1ns / 1ps
module maof_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [1:0]                           cfg_data,
  input  wire logic                                 accum_valid,
  input  wire logic                                 accum_stall,
  input  wire logic signed [maof_pkg::SAMPLE_W-1:0] accum_sample,
  input  wire logic                                 last_in,
  input  wire logic                                 code_valid,
  input  wire logic                                 code_stall,
  input  wire logic [maof_pkg::CODE_W-1:0]          out_code,
  input  wire logic                                 last_out,
  output int                                        mismatches,
  output int                                        pending,
  output int                                        checked
);

  localparam int LIN8_HI    = 127;
  localparam int LIN8_LO    = -127;
  localparam int LIN16_HI   = 32767;
  localparam int LIN16_LO   = -32768;
  localparam int MULAW_HI   = 4095;
  localparam int MULAW_LO   = -4096;
  localparam int LIN8_MID   = 'h80;
  localparam int LIN16_MID  = 'h8000;
  localparam int ULAW_CLIP  = 8159;
  localparam int ULAW_BIAS  = 33;
  localparam int ULAW_KNEE  = 'h3F;
  localparam int ULAW_SEGS  = 7;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [maof_pkg::CODE_W-1:0]          code;
    logic                                 last;
    logic signed [maof_pkg::SAMPLE_W-1:0] sample;
    logic [1:0]                           fmt;
    logic                                 uns;
  } code_beat_t;

  code_beat_t  code_queue[$];
  logic [1:0]  cur_fmt;
  logic        cur_uns;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [7:0] mulaw_code(int lin);
    int         mag;
    int         seg;
    logic [7:0] flip;
    if (lin < 0) begin
      mag  = -lin;
      flip = maof_pkg::MULAW_MASK_NEG;
    end else begin
      mag  = lin;
      flip = maof_pkg::MULAW_MASK_POS;
    end
    if (mag > ULAW_CLIP) mag = ULAW_CLIP;
    mag += ULAW_BIAS;
    seg = 0;
    while (seg < ULAW_SEGS && mag > (ULAW_KNEE << seg)) seg++;
    return {1'b0, seg[2:0], 4'(mag >> (seg + 1))} ^ flip;
  endfunction

  function automatic logic [maof_pkg::CODE_W-1:0] format_code(logic [1:0] fmt, logic uns,
                                   logic signed [maof_pkg::SAMPLE_W-1:0] s);
    int v;
    case (fmt)
      maof_pkg::FMT_MULAW: begin
        v = clamp_to(s >>> maof_pkg::MULAW_SH, MULAW_LO, MULAW_HI);
        return {8'h00, mulaw_code(2 * v)};
      end
      maof_pkg::FMT_LIN8: begin
        v = clamp_to(s >>> maof_pkg::LIN8_SH, LIN8_LO, LIN8_HI);
        if (uns) v += LIN8_MID;
        return {8'h00, 8'(v)};
      end
      default: begin
        v = clamp_to(s >>> maof_pkg::LIN16_SH, LIN16_LO, LIN16_HI);
        if (uns) v += LIN16_MID;
        return 16'(v);
      end
    endcase
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    cur_fmt    = maof_pkg::FMT_LIN16;
    cur_uns    = 1'b0;
  end

  always @(posedge clk) begin
    code_beat_t exp_beat;
    code_beat_t new_beat;
    if (rst) begin
      cur_fmt = maof_pkg::FMT_LIN16;
      cur_uns = 1'b0;
      code_queue.delete();
    end else begin
      if (code_valid && !code_stall) begin
        checked++;
        if (code_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected code beat: code %h last %b", out_code, last_out);
        end else begin
          exp_beat = code_queue.pop_front();
          if (out_code !== exp_beat.code || last_out !== exp_beat.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("code mismatch: sample %h fmt %0d uns %b expected %h/%b got %h/%b",
                       exp_beat.sample, exp_beat.fmt, exp_beat.uns, exp_beat.code,
                       exp_beat.last, out_code, last_out);
          end
        end
      end
      if (accum_valid && !accum_stall) begin
        new_beat.sample = accum_sample;
        new_beat.fmt    = cur_fmt;
        new_beat.uns    = cur_uns;
        new_beat.code   = format_code(cur_fmt, cur_uns, accum_sample);
        new_beat.last   = last_in;
        code_queue.push_back(new_beat);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == maof_pkg::REG_FORMAT) cur_fmt = cfg_data;
        else cur_uns = cfg_data[0];
      end
    end
    pending = code_queue.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [1:0] FMT_SPARE    = 2'd3;
  localparam int         NUM_PHASES   = 8;
  localparam int         RAND_ITEMS   = 100;
  localparam int         DIRECTED_N   = 8;
  localparam int         PRESS_PHASE  = 4;
  localparam int         PRESS_CYCLES = 80;
  localparam int         DRAIN_CYCLES = 4;

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic                                 cfg_index;
  logic [1:0]                           cfg_data;
  logic                                 accum_valid;
  logic                                 accum_stall;
  logic signed [maof_pkg::SAMPLE_W-1:0] accum_sample;
  logic                                 last_in;
  logic                                 code_valid;
  logic                                 code_stall;
  logic [maof_pkg::CODE_W-1:0]          out_code;
  logic                                 last_out;

  int   mismatches;
  int   pending;
  int   checked;
  logic press_go;
  logic press_done;
  logic burst;
  int   directed_sent;
  int   random_sent;

  typedef struct {
    logic [1:0] fmt;
    logic       uns;
  } fmt_setting_t;

  fmt_setting_t settings[NUM_PHASES];

  mix_accumulator_output_formatter_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accum_valid  (accum_valid),
    .accum_stall  (accum_stall),
    .accum_sample (accum_sample),
    .last_in      (last_in),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .out_code     (out_code),
    .last_out     (last_out)
  );

  maof_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accum_valid  (accum_valid),
    .accum_stall  (accum_stall),
    .accum_sample (accum_sample),
    .last_in      (last_in),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .out_code     (out_code),
    .last_out     (last_out),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Shift and clamp range of each format, for stimulus aimed at the clamp edges.
  function automatic void format_range(logic [1:0] fmt, output int sh, output int lo,
                                       output int hi);
    case (fmt)
      maof_pkg::FMT_MULAW: begin sh = maof_pkg::MULAW_SH; lo = -4096;  hi = 4095;  end
      maof_pkg::FMT_LIN8:  begin sh = maof_pkg::LIN8_SH;  lo = -127;   hi = 127;   end
      default:             begin sh = maof_pkg::LIN16_SH; lo = -32768; hi = 32767; end
    endcase
  endfunction

  function automatic logic signed [maof_pkg::SAMPLE_W-1:0] edge_sample(logic [1:0] fmt,
                                                                       int k);
    int sh;
    int lo;
    int hi;
    format_range(fmt, sh, lo, hi);
    case (k)
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0;
      3: return -32'sd1;
      4: return hi <<< sh;
      5: return (hi + 1) <<< sh;
      6: return lo <<< sh;
      default: return (lo <<< sh) - 1;
    endcase
  endfunction

  function automatic logic signed [maof_pkg::SAMPLE_W-1:0] random_sample(logic [1:0] fmt);
    int sh;
    int lo;
    int hi;
    int v;
    format_range(fmt, sh, lo, hi);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        v = ($urandom_range(0, 1) ? hi : lo) + int'($urandom_range(0, 4)) - 2;
        return (v <<< sh) + int'($urandom_range(0, (1 << sh) - 1));
      end
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic int sender_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_reg(logic idx, logic [1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_sample(logic signed [maof_pkg::SAMPLE_W-1:0] s, logic last);
    accum_valid  = 1'b1;
    accum_sample = s;
    last_in      = last;
    @(posedge clk);
    while (accum_stall) @(posedge clk);
    @(negedge clk);
    accum_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stall stretches, plus one long hold-off on request.
  initial begin
    int r;
    code_stall = 1'b0;
    press_done = 1'b0;
    forever begin
      if (press_go && !press_done) begin
        code_stall = 1'b1;
        repeat (PRESS_CYCLES) @(negedge clk);
        press_done = 1'b1;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          code_stall = 1'b0;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end else if (r < 8) begin
          code_stall = 1'b1;
          repeat ($urandom_range(1, 3)) @(negedge clk);
        end else if (r == 8) begin
          code_stall = 1'b1;
          repeat ($urandom_range(8, 30)) @(negedge clk);
        end else begin
          code_stall = 1'b0;
          repeat ($urandom_range(30, 60)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = maof_pkg::REG_FORMAT;
    cfg_data      = '0;
    accum_valid   = 1'b0;
    accum_sample  = '0;
    last_in       = 1'b0;
    press_go      = 1'b0;
    burst         = 1'b0;
    directed_sent = 0;
    random_sent   = 0;
    settings = '{'{maof_pkg::FMT_MULAW, 1'b0}, '{maof_pkg::FMT_MULAW, 1'b1},
                 '{maof_pkg::FMT_LIN8, 1'b0},  '{maof_pkg::FMT_LIN8, 1'b1},
                 '{maof_pkg::FMT_LIN16, 1'b0}, '{maof_pkg::FMT_LIN16, 1'b1},
                 '{FMT_SPARE, 1'b0},           '{FMT_SPARE, 1'b1}};
    repeat (4) @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(maof_pkg::REG_FORMAT, settings[p].fmt);
      write_reg(maof_pkg::REG_UNSIGNED, {1'b0, settings[p].uns});
      if (!settings[p].uns && settings[p].fmt != FMT_SPARE) begin
        for (int k = 0; k < DIRECTED_N; k++) begin
          send_sample(edge_sample(settings[p].fmt, k), k[0]);
          directed_sent++;
        end
      end
      if (p == PRESS_PHASE) press_go = 1'b1;
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if ($urandom_range(0, 19) == 0) burst = !burst;
        repeat (sender_gap()) @(negedge clk);
        send_sample(random_sample(settings[p].fmt), 1'($urandom_range(0, 1)));
        random_sent++;
      end
    end

    wait_idle();
    $display("summary: %0d directed and %0d random samples over %0d format settings,",
             directed_sent, random_sent, NUM_PHASES);
    $display("summary: %0d codes compared, %0d mismatches, one long output hold-off",
             checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
